### rtl/core/blc_pkg.sv
package blc_pkg;

	// Default sizing
	localparam int ENTRIES_DEF  = 16;
	localparam int OVERHEAD_DEF = 1024;

	// Internal index and count widths cover the largest table (256 entries)
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	// Field widths
	localparam int OP_W     = 3;
	localparam int KEY_W    = 32;
	localparam int VC_W     = 24;
	localparam int VS_W     = 8;
	localparam int IC_W     = 24;
	localparam int COST_W   = 32;
	localparam int SUM_W    = 34;
	localparam int STAT_W   = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int EVC_W    = 5;
	localparam int ECNT_W   = 5;
	localparam int IN_W     = 96;
	localparam int OUT_W    = 184;

	localparam logic [STAT_W-1:0] BUDGET_MIN   = 32'd1024;
	localparam logic [STAT_W-1:0] BUDGET_RESET = 32'd67108864;

	// Operation codes
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
	localparam logic [OP_W-1:0] OP_TRIM   = 3'd4;
	localparam logic [OP_W-1:0] OP_RSTAT  = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOBUDGET = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd5;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_TOUCH  = 3'd1,
		CMD_DROP   = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_op_t;

	// Command broadcast to every cell
	typedef struct packed {
		cmd_op_t            op;
		logic [IDX_W-1:0]   slot;
		logic [IDX_W-1:0]   rank;
		logic [KEY_W-1:0]   tag;
		logic [COST_W-1:0]  cost;
		logic [VC_W-1:0]    vc;
		logic [IC_W-1:0]    ic;
	} cmd_t;

	// Search broadcast: match by tag, or by recency rank
	typedef struct packed {
		logic               by_rank;
		logic [KEY_W-1:0]   key;
		logic [IDX_W-1:0]   rank;
	} search_t;

	// Result passed from cell to cell
	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   slot;
		logic [IDX_W-1:0]   rank;
		logic [COST_W-1:0]  cost;
		logic [VC_W-1:0]    vc;
		logic [IC_W-1:0]    ic;
		logic               free_found;
		logic [IDX_W-1:0]   free_slot;
	} chain_t;

endpackage

### rtl/core/byte_budget_lru_cache_top.sv
// Keyed LRU cache of up to ENTRIES records held in a row of cells, kept within a
// byte budget (cost = vertex_count*vertex_stride + index_count*4 + ENTRY_OVERHEAD).
// One item in, one result out. Each item passes through a multiply state (S_CALC), a key
// search through the cell row (S_FIND) and an execute state (S_EXEC). Lookup, remove,
// clear, reset-stats, the unused op codes and an insert with key zero or an existing key
// end there; an insert goes on to a free-slot pass (S_PLACE), and when over budget first
// evicts (S_EVICT) and checks the budget again (S_CHECK), refused if still over budget;
// trim evicts least recent entries in S_TRIM until within budget or empty.
// A new item is taken once the previous result has been taken or is being taken.
module byte_budget_lru_cache_top #(
	parameter int ENTRIES        = blc_pkg::ENTRIES_DEF,
	parameter int ENTRY_OVERHEAD = blc_pkg::OVERHEAD_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [blc_pkg::STAT_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// op[2:0], key[34:3], vertex_count[58:35], vertex_stride[66:59], index_count[90:67]
	input  logic [blc_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status[2:0], slot[6:3], evicted_count[11:7], bytes_in_use[43:12],
	// entry_count[48:44], hit_count[80:49], miss_count[112:81],
	// total_vertices[144:113], total_indices[176:145]
	output logic [blc_pkg::OUT_W-1:0]  m_tdata
);
	import blc_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CALC  = 8'b0000_0010,
		S_FIND  = 8'b0000_0100,
		S_EXEC  = 8'b0000_1000,
		S_EVICT = 8'b0001_0000,
		S_CHECK = 8'b0010_0000,
		S_PLACE = 8'b0100_0000,
		S_TRIM  = 8'b1000_0000
	} state_t;

	state_t              state_q, nstate;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VC_W-1:0]     vc_q;
	logic [VS_W-1:0]     vs_q;
	logic [IC_W-1:0]     ic_q;
	logic [COST_W-1:0]   prod_s1;
	logic [SUM_W-1:0]    cost_q;
	chain_t              found_q;
	logic [STAT_W-1:0]   budget_q;
	logic [STAT_W-1:0]   usage_q, usage_n;
	logic [STAT_W-1:0]   hits_q, hits_n;
	logic [STAT_W-1:0]   miss_q, miss_n;
	logic [STAT_W-1:0]   vert_q, vert_n;
	logic [STAT_W-1:0]   idx_q, idx_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;
	logic [CNT_W-1:0]    evc_q, evc_n;
	logic [STATUS_W-1:0] status_q, status_n;
	logic [IDX_W-1:0]    slot_q, slot_n;
	logic                m_tvalid_q;
	logic                fin;
	logic                accept;
	logic                over;
	logic                trim_over;
	cmd_t                cmd;
	search_t             srch;
	chain_t              chain_w [0:ENTRIES];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;

	assign over      = ({2'b00, usage_q} + cost_q) > {2'b00, budget_q};
	assign trim_over = (usage_q > budget_q) && (cnt_q != '0);

	// Search by tag, except while evicting the least recent entry
	assign srch.by_rank = (state_q == S_EVICT) || (state_q == S_TRIM);
	assign srch.key     = key_q;
	assign srch.rank    = IDX_W'(cnt_q - 1'b1);

	// Row of cells
	assign chain_w[0] = '0;
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		blc_cell #(.INDEX(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.srch      (srch),
			.chain_in  (chain_w[i]),
			.chain_out (chain_w[i+1])
		);
	end

	// Sequencer: next state, cell command and updated totals
	always_comb begin
		nstate   = state_q;
		fin      = 1'b0;
		cmd      = '0;
		cmd.op   = CMD_NONE;
		usage_n  = usage_q;
		hits_n   = hits_q;
		miss_n   = miss_q;
		vert_n   = vert_q;
		idx_n    = idx_q;
		cnt_n    = cnt_q;
		evc_n    = evc_q;
		status_n = status_q;
		slot_n   = slot_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					nstate   = S_CALC;
					evc_n    = '0;
					status_n = ST_OK;
					slot_n   = '0;
				end
			end
			S_CALC: nstate = S_FIND;
			S_FIND: nstate = S_EXEC;
			S_EXEC: begin
				case (op_q)
					OP_LOOKUP: begin
						fin = 1'b1;
						if (key_q == '0) begin
							status_n = ST_INVALID;
						end else if (found_q.found) begin
							hits_n   = hits_q + 1'b1;
							cmd.op   = CMD_TOUCH;
							cmd.slot = found_q.slot;
							cmd.rank = found_q.rank;
							slot_n   = found_q.slot;
						end else begin
							miss_n   = miss_q + 1'b1;
							status_n = ST_MISS;
						end
					end
					OP_INSERT: begin
						if (key_q == '0) begin
							fin      = 1'b1;
							status_n = ST_INVALID;
						end else if (found_q.found) begin
							fin      = 1'b1;
							status_n = ST_DUP;
							slot_n   = found_q.slot;
						end else if (over) begin
							nstate = S_EVICT;
						end else begin
							nstate = S_PLACE;
						end
					end
					OP_REMOVE: begin
						fin = 1'b1;
						if (key_q == '0) begin
							status_n = ST_INVALID;
						end else if (found_q.found) begin
							cmd.op   = CMD_DROP;
							cmd.slot = found_q.slot;
							cmd.rank = found_q.rank;
							usage_n  = usage_q - found_q.cost;
							vert_n   = vert_q - STAT_W'(found_q.vc);
							idx_n    = idx_q - STAT_W'(found_q.ic);
							cnt_n    = cnt_q - 1'b1;
						end else begin
							status_n = ST_MISS;
						end
					end
					OP_CLEAR: begin
						fin     = 1'b1;
						cmd.op  = CMD_CLEAR;
						usage_n = '0;
						hits_n  = '0;
						miss_n  = '0;
						vert_n  = '0;
						idx_n   = '0;
						cnt_n   = '0;
					end
					OP_TRIM: nstate = S_TRIM;
					OP_RSTAT: begin
						fin    = 1'b1;
						hits_n = '0;
						miss_n = '0;
					end
					default: fin = 1'b1;
				endcase
			end
			S_EVICT: begin
				nstate = S_CHECK;
				if (cnt_q != '0) begin
					cmd.op   = CMD_DROP;
					cmd.slot = chain_w[ENTRIES].slot;
					cmd.rank = chain_w[ENTRIES].rank;
					usage_n  = usage_q - chain_w[ENTRIES].cost;
					vert_n   = vert_q - STAT_W'(chain_w[ENTRIES].vc);
					idx_n    = idx_q - STAT_W'(chain_w[ENTRIES].ic);
					cnt_n    = cnt_q - 1'b1;
					evc_n    = CNT_W'(1);
				end
			end
			S_CHECK: begin
				if (over) begin
					fin      = 1'b1;
					status_n = ST_NOBUDGET;
				end else begin
					nstate = S_PLACE;
				end
			end
			S_PLACE: begin
				fin = 1'b1;
				if (!chain_w[ENTRIES].free_found) begin
					status_n = ST_FULL;
				end else begin
					cmd.op   = CMD_INSERT;
					cmd.slot = chain_w[ENTRIES].free_slot;
					cmd.tag  = key_q;
					cmd.cost = cost_q[COST_W-1:0];
					cmd.vc   = vc_q;
					cmd.ic   = ic_q;
					usage_n  = usage_q + cost_q[COST_W-1:0];
					vert_n   = vert_q + STAT_W'(vc_q);
					idx_n    = idx_q + STAT_W'(ic_q);
					cnt_n    = cnt_q + 1'b1;
					slot_n   = chain_w[ENTRIES].free_slot;
				end
			end
			S_TRIM: begin
				if (trim_over) begin
					cmd.op   = CMD_DROP;
					cmd.slot = chain_w[ENTRIES].slot;
					cmd.rank = chain_w[ENTRIES].rank;
					usage_n  = usage_q - chain_w[ENTRIES].cost;
					vert_n   = vert_q - STAT_W'(chain_w[ENTRIES].vc);
					idx_n    = idx_q - STAT_W'(chain_w[ENTRIES].ic);
					cnt_n    = cnt_q - 1'b1;
					evc_n    = evc_q + 1'b1;
				end else begin
					fin = 1'b1;
				end
			end
			default: nstate = S_IDLE;
		endcase
		if (fin) nstate = S_IDLE;
	end

	// Control state, totals and budget register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			budget_q   <= BUDGET_RESET;
			usage_q    <= '0;
			hits_q     <= '0;
			miss_q     <= '0;
			vert_q     <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
		end else begin
			state_q <= nstate;
			usage_q <= usage_n;
			hits_q  <= hits_n;
			miss_q  <= miss_n;
			vert_q  <= vert_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
			if (fin) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (cfg_we) budget_q <= (cfg_wdata < BUDGET_MIN) ? BUDGET_MIN : cfg_wdata;
		end
	end

	// Item capture, cost arithmetic and result fields
	always_ff @(posedge clk) begin
		evc_q    <= evc_n;
		status_q <= status_n;
		slot_q   <= slot_n;
		if (accept) begin
			op_q  <= s_tdata[2:0];
			key_q <= s_tdata[34:3];
			vc_q  <= s_tdata[58:35];
			vs_q  <= s_tdata[66:59];
			ic_q  <= s_tdata[90:67];
		end
		if (state_q == S_CALC) prod_s1 <= COST_W'(vc_q * vs_q);
		if (state_q == S_FIND) begin
			cost_q  <= {2'b00, prod_s1} + {8'b0, ic_q, 2'b00} + SUM_W'(ENTRY_OVERHEAD);
			found_q <= chain_w[ENTRIES];
		end
	end

	assign m_tdata = {7'b0, idx_q, vert_q, miss_q, hits_q, ECNT_W'(cnt_q), usage_q,
		EVC_W'(evc_q), SLOT_W'(slot_q), status_q};

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES)) else $error("entry count above table size");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE && chain_w[ENTRIES].free_found) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not raise entry count");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_q == OP_CLEAR) |=> (cnt_q == '0 && usage_q == '0))
		else $error("clear left entries or usage");

	a_trim_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRIM && fin) |-> !trim_over)
		else $error("trim finished over budget");

endmodule

### rtl/core/blc_cell.sv
module blc_cell #(
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  blc_pkg::cmd_t    cmd,
	input  blc_pkg::search_t srch,
	input  blc_pkg::chain_t  chain_in,
	output blc_pkg::chain_t  chain_out
);
	import blc_pkg::*;

	logic               valid_q;
	logic [KEY_W-1:0]   tag_q;
	logic [COST_W-1:0]  cost_q;
	logic [VC_W-1:0]    vc_q;
	logic [IC_W-1:0]    ic_q;
	logic [IDX_W-1:0]   rank_q;
	logic               mine;
	logic               match;

	assign mine  = (cmd.slot == IDX_W'(INDEX));
	assign match = valid_q && (srch.by_rank ? (rank_q == srch.rank) : (tag_q == srch.key));

	// Pass the first match and the first free slot down the row
	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && match) begin
			chain_out.found = 1'b1;
			chain_out.slot  = IDX_W'(INDEX);
			chain_out.rank  = rank_q;
			chain_out.cost  = cost_q;
			chain_out.vc    = vc_q;
			chain_out.ic    = ic_q;
		end
		if (!chain_in.free_found && !valid_q) begin
			chain_out.free_found = 1'b1;
			chain_out.free_slot  = IDX_W'(INDEX);
		end
	end

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_DROP:   if (mine) valid_q <= 1'b0;
				CMD_INSERT: if (mine) valid_q <= 1'b1;
				CMD_CLEAR:  valid_q <= 1'b0;
				default:    ;
			endcase
		end
	end

	// Entry payload and recency rank
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_TOUCH: begin
				if (mine) rank_q <= '0;
				else if (valid_q && rank_q < cmd.rank) rank_q <= rank_q + 1'b1;
			end
			CMD_DROP: begin
				if (!mine && valid_q && rank_q > cmd.rank) rank_q <= rank_q - 1'b1;
			end
			CMD_INSERT: begin
				if (mine) begin
					rank_q <= '0;
					tag_q  <= cmd.tag;
					cost_q <= cmd.cost;
					vc_q   <= cmd.vc;
					ic_q   <= cmd.ic;
				end else if (valid_q) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

### sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import blc_pkg::*;

	// Predicted result of one cache operation
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [EVC_W-1:0]    evicted;
		logic [31:0]         bytes_used;
		logic [ECNT_W-1:0]   entries;
		logic [31:0]         hits;
		logic [31:0]         misses;
		logic [31:0]         verts;
		logic [31:0]         idxs;
	} cache_result_t;

	// Mirror of the cache contents; predicts and checks results
	class cache_scoreboard;
		logic [31:0] budget;
		logic [31:0] tag [16];
		bit          vld [16];
		logic [31:0] cost [16];
		logic [23:0] vcnt [16];
		logic [23:0] icnt [16];
		int unsigned rank [16];
		logic [31:0] used, hits, misses, verts, idxs;
		cache_result_t pending[$];
		int errors;

		function new();
			budget = BUDGET_RESET;
			used = 0; hits = 0; misses = 0; verts = 0; idxs = 0;
			errors = 0;
			for (int i = 0; i < 16; i++) begin
				vld[i] = 0; rank[i] = 0;
			end
		endfunction

		function void set_budget(logic [31:0] v);
			budget = (v < BUDGET_MIN) ? BUDGET_MIN : v;
		endfunction

		function int find(logic [31:0] k);
			for (int i = 0; i < 16; i++)
				if (vld[i] && tag[i] == k) return i;
			return -1;
		endfunction

		function void drop(int s);
			vld[s] = 0;
			used -= cost[s];
			verts -= 32'(vcnt[s]);
			idxs -= 32'(icnt[s]);
			for (int i = 0; i < 16; i++)
				if (vld[i] && rank[i] > rank[s]) rank[i]--;
		endfunction

		function bit evict_oldest();
			int b;
			b = -1;
			for (int i = 0; i < 16; i++)
				if (vld[i] && (b < 0 || rank[i] > rank[b])) b = i;
			if (b < 0) return 0;
			drop(b);
			return 1;
		endfunction

		// Apply one accepted item and queue its result
		function void note_item(logic [IN_W-1:0] d);
			logic [2:0] op;
			logic [31:0] k;
			logic [23:0] vc, ic;
			logic [7:0] vs;
			logic [63:0] c;
			cache_result_t r;
			int s, n;
			op = d[2:0]; k = d[34:3]; vc = d[58:35]; vs = d[66:59]; ic = d[90:67];
			r = '0;
			case (op)
				OP_LOOKUP: begin
					if (k == 0) r.status = ST_INVALID;
					else begin
						s = find(k);
						if (s >= 0) begin
							hits++;
							for (int i = 0; i < 16; i++)
								if (vld[i] && rank[i] < rank[s]) rank[i]++;
							rank[s] = 0;
							r.slot = SLOT_W'(s);
						end else begin
							misses++;
							r.status = ST_MISS;
						end
					end
				end
				OP_INSERT: begin
					if (k == 0) r.status = ST_INVALID;
					else if (find(k) >= 0) begin
						r.status = ST_DUP;
						r.slot = SLOT_W'(find(k));
					end else begin
						c = 64'(vc) * 64'(vs) + 64'(ic) * 4 + 64'd1024;
						if (64'(used) + c > 64'(budget)) begin
							if (evict_oldest()) r.evicted = EVC_W'(1);
						end
						if (64'(used) + c > 64'(budget)) r.status = ST_NOBUDGET;
						else begin
							s = -1;
							for (int i = 15; i >= 0; i--) if (!vld[i]) s = i;
							if (s < 0) r.status = ST_FULL;
							else begin
								for (int i = 0; i < 16; i++) if (vld[i]) rank[i]++;
								vld[s] = 1; rank[s] = 0; tag[s] = k;
								cost[s] = c[31:0]; vcnt[s] = vc; icnt[s] = ic;
								used += c[31:0]; verts += 32'(vc); idxs += 32'(ic);
								r.slot = SLOT_W'(s);
							end
						end
					end
				end
				OP_REMOVE: begin
					if (k == 0) r.status = ST_INVALID;
					else begin
						s = find(k);
						if (s >= 0) drop(s);
						else r.status = ST_MISS;
					end
				end
				OP_CLEAR: begin
					for (int i = 0; i < 16; i++) vld[i] = 0;
					used = 0; hits = 0; misses = 0; verts = 0; idxs = 0;
				end
				OP_TRIM: begin
					while (used > budget && evict_oldest()) r.evicted++;
				end
				OP_RSTAT: begin
					hits = 0; misses = 0;
				end
				default: ;
			endcase
			n = 0;
			for (int i = 0; i < 16; i++) if (vld[i]) n++;
			r.bytes_used = used; r.entries = ECNT_W'(n); r.hits = hits; r.misses = misses;
			r.verts = verts; r.idxs = idxs;
			pending = {pending, r};
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(logic [OUT_W-1:0] d);
			cache_result_t e, a;
			a.status = d[2:0]; a.slot = d[6:3]; a.evicted = d[11:7];
			a.bytes_used = d[43:12]; a.entries = d[48:44]; a.hits = d[80:49];
			a.misses = d[112:81]; a.verts = d[144:113]; a.idxs = d[176:145];
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.status !== a.status)
				$display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
			if (e.slot !== a.slot)
				$display("%0t: slot expected %0d actual %0d", $time, e.slot, a.slot);
			if (e.evicted !== a.evicted)
				$display("%0t: evicted expected %0d actual %0d", $time, e.evicted, a.evicted);
			if (e.bytes_used !== a.bytes_used)
				$display("%0t: bytes expected %0d actual %0d", $time, e.bytes_used,
					a.bytes_used);
			if (e.entries !== a.entries)
				$display("%0t: entries expected %0d actual %0d", $time, e.entries, a.entries);
			if (e.hits !== a.hits)
				$display("%0t: hits expected %0d actual %0d", $time, e.hits, a.hits);
			if (e.misses !== a.misses)
				$display("%0t: misses expected %0d actual %0d", $time, e.misses, a.misses);
			if (e.verts !== a.verts)
				$display("%0t: vertices expected %0d actual %0d", $time, e.verts, a.verts);
			if (e.idxs !== a.idxs)
				$display("%0t: indices expected %0d actual %0d", $time, e.idxs, a.idxs);
			if (e !== a) errors++;
		endfunction
	endclass

	logic clk, arst_n, cfg_we, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [31:0] cfg_wdata;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;
	cache_scoreboard sb;
	int unsigned cycles;
	int idle_pct;

	byte_budget_lru_cache_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Timeout guard
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// Receiver: random stall, check each accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// Send one item, idling first at random; tvalid stays up until the next idle
	task automatic send_item(logic [2:0] op, logic [31:0] k, logic [23:0] vc,
		logic [7:0] vs, logic [23:0] ic);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'd0, ic, vs, vc, k, op};
		do @(posedge clk); while (!s_tready);
		sb.note_item({5'd0, ic, vs, vc, k, op});
	endtask

	// Drain results, then write the budget
	task automatic write_budget(logic [31:0] v);
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_budget(v);
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(19) == 0) return $urandom;
		return $urandom_range(24, 1);
	endfunction

	initial begin
		logic [2:0] op;
		logic [31:0] bud;
		sb = new();
		idle_pct = 34;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; s_tvalid = 0; s_tdata = 0; m_tready = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: key zero, duplicates, extremes, every op
		send_item(OP_LOOKUP, 0, 0, 0, 0);
		send_item(OP_INSERT, 0, 1, 1, 1);
		send_item(OP_REMOVE, 0, 0, 0, 0);
		send_item(OP_INSERT, 32'hFFFFFFFF, 0, 0, 0);
		send_item(OP_INSERT, 32'hFFFFFFFF, 5, 5, 5);
		send_item(OP_LOOKUP, 32'hFFFFFFFF, 0, 0, 0);
		send_item(OP_LOOKUP, 7, 0, 0, 0);
		send_item(OP_INSERT, 2, 24'hFFFFFF, 8'hFF, 24'hFFFFFF);
		for (int i = 3; i < 20; i++) send_item(OP_INSERT, 32'(i), 24'(i), 4, 24'(i));
		send_item(OP_REMOVE, 5, 0, 0, 0);
		send_item(OP_REMOVE, 5, 0, 0, 0);
		send_item(3'd6, 1, 0, 0, 0);
		send_item(3'd7, 1, 0, 0, 0);
		send_item(OP_RSTAT, 0, 0, 0, 0);
		write_budget(0);
		send_item(OP_TRIM, 0, 0, 0, 0);
		send_item(OP_INSERT, 9, 0, 0, 0);
		send_item(OP_INSERT, 10, 1, 1, 0);
		write_budget(32'hFFFFFFFF);
		send_item(OP_INSERT, 11, 24'hFFFFFF, 8'hFF, 24'hFFFFFF);
		send_item(OP_CLEAR, 0, 0, 0, 0);

		// Random phases with varied budgets; one phase runs with no idling
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: bud = $urandom_range(20000, 1024);
				1: bud = $urandom_range(200000, 20000);
				2: bud = $urandom;
				default: bud = (ph == 3) ? 32'd1024 : 32'hFFFFFFFF;
			endcase
			write_budget(bud);
			idle_pct = (ph == 5) ? 0 : 34;
			for (int n = 0; n < 90; n++) begin
				case ($urandom_range(99)) inside
					[0:39]:  op = OP_LOOKUP;
					[40:74]: op = OP_INSERT;
					[75:87]: op = OP_REMOVE;
					[88:92]: op = OP_TRIM;
					[93:95]: op = OP_RSTAT;
					[96:97]: op = OP_CLEAR;
					default: op = 3'($urandom_range(7, 6));
				endcase
				if ($urandom_range(15) == 0)
					send_item(op, pick_key(), 24'($urandom), 8'($urandom), 24'($urandom));
				else
					send_item(op, pick_key(), 24'($urandom_range(3000)),
						8'($urandom_range(64)), 24'($urandom_range(3000)));
			end
			if (ph == 3) send_item(OP_TRIM, 0, 0, 0, 0);
		end

		// Drain and finish
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
